>>> src/dsa_pkg.sv
package dsa_pkg;

   localparam int ADDR_W   = 64;
   localparam int SIZE_W   = 13;
   localparam int FRAME_W  = 3;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 3;

   localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RECLAIM = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NULL  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_BAD   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FRAME = 3'd4;

   localparam logic [1:0] REG_SLOT_SIZE      = 2'd0;
   localparam logic [1:0] REG_CPU_BASE       = 2'd1;
   localparam logic [1:0] REG_GPU_BASE       = 2'd2;
   localparam logic [1:0] REG_SHADER_VISIBLE = 2'd3;

   localparam logic [2:0] OP_HOLD     = 3'd0;
   localparam logic [2:0] OP_LOAD     = 3'd1;
   localparam logic [2:0] OP_SUB      = 3'd2;
   localparam logic [2:0] OP_STEP_DIV = 3'd3;
   localparam logic [2:0] OP_STEP_MUL = 3'd4;
   localparam logic [2:0] OP_ADD      = 3'd5;

   typedef struct packed {
      logic [2:0]        op;
      logic [ADDR_W-1:0] operand;
   } arith_cmd_type;

endpackage

>>> src/dsa_ram.sv
module dsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/dsa_arith.sv
module dsa_arith #(
   parameter int ACC_W = 21
) (
   input  logic                           clock,
   input  dsa_pkg::arith_cmd_type         cmd,
   input  logic [dsa_pkg::SIZE_W-1:0]     slot_size,
   output logic [dsa_pkg::ADDR_W-1:0]     work,
   output logic                           borrow
);

   localparam int AW = dsa_pkg::ADDR_W;

   logic [AW-1:0]    work_ff, work_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic             borrow_ff, borrow_in;

   logic             step_sub;
   logic [ACC_W-1:0] step_a, step_b;
   logic [ACC_W:0]   step_sum;

   logic             wide_sub;
   logic [AW-1:0]    wide_a, wide_b;
   logic [AW:0]      wide_sum;

   always_comb begin
      step_sub = (cmd.op == dsa_pkg::OP_STEP_DIV);
      if (step_sub) begin
         step_a = {acc_ff[ACC_W-2:0], work_ff[AW-1]};
         step_b = ACC_W'(slot_size);
      end else begin
         step_a = {acc_ff[ACC_W-2:0], 1'b0};
         step_b = work_ff[AW-1] ? ACC_W'(slot_size) : '0;
      end
      step_sum = {1'b0, step_a} + {1'b0, (step_sub ? ~step_b : step_b)}
               + (ACC_W+1)'(step_sub);

      wide_sub = (cmd.op == dsa_pkg::OP_SUB);
      wide_a   = wide_sub ? work_ff : AW'(acc_ff);
      wide_b   = wide_sub ? ~cmd.operand : cmd.operand;
      wide_sum = {1'b0, wide_a} + {1'b0, wide_b} + (AW+1)'(wide_sub);
   end

   always_comb begin
      work_in   = work_ff;
      acc_in    = acc_ff;
      borrow_in = borrow_ff;
      case (cmd.op)
         dsa_pkg::OP_LOAD: begin
            work_in = cmd.operand;
            acc_in  = '0;
         end
         dsa_pkg::OP_SUB: begin
            work_in   = wide_sum[AW-1:0];
            borrow_in = ~wide_sum[AW];
         end
         dsa_pkg::OP_STEP_DIV: begin
            if (step_sum[ACC_W]) begin
               acc_in  = step_sum[ACC_W-1:0];
               work_in = {work_ff[AW-2:0], 1'b1};
            end else begin
               acc_in  = step_a;
               work_in = {work_ff[AW-2:0], 1'b0};
            end
         end
         dsa_pkg::OP_STEP_MUL: begin
            acc_in  = step_sum[ACC_W-1:0];
            work_in = {work_ff[AW-2:0], 1'b0};
         end
         dsa_pkg::OP_ADD: begin
            work_in = wide_sum[AW-1:0];
         end
         default: begin
            work_in = work_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      work_ff   <= work_in;
      acc_ff    <= acc_in;
      borrow_ff <= borrow_in;
   end

   assign work   = work_ff;
   assign borrow = borrow_ff;

endmodule

>>> src/descriptor_slot_allocator.sv
// Allocator of descriptor slots over a fixed heap: a stack of free slot indices in a RAM,
// per-frame lists of freed slots in a second RAM, and one shared shift-and-add unit that
// forms slot offsets (one multiplier bit per cycle) and turns addresses back into slot
// indices (one quotient bit per cycle). One transaction is worked on at a time and
// req_tready is low meanwhile. An allocate is bounded by its multiply steps; a free by the
// 64 division steps over the address, unless the address lies below the CPU base, which
// ends it before they start; a reclaim does one pending-list read and at most one
// free-stack write per parked slot; requests rejected at acceptance go straight to the
// result. The result becomes valid in the same cycle as the block is ready again, and a
// full output register holds the block back until it drains. After reset a clearing pass
// fills the free stack in identity order, and no request is accepted until it ends. A
// finished result waits in the output register while the next request is already accepted.
module descriptor_slot_allocator #(
   parameter int SLOT_COUNT  = 256,
   parameter int FRAME_COUNT = 3
) (
   input  logic                                        clock,
   input  logic                                        reset,

   input  logic                                        req_tvalid,
   output logic                                        req_tready,
   // Fields from bit 0 up: handle_address (64), frame_index (3), zero fill.
   input  logic [71:0]                                 req_tdata,
   // Fields from bit 0 up: func (2).
   input  logic [dsa_pkg::FUNC_W-1:0]                  req_tuser,

   output logic                                        rsp_tvalid,
   input  logic                                        rsp_tready,
   // Fields from bit 0 up: slot_index, cpu_address (64), gpu_address (64),
   // reclaimed_count, zero fill.
   output logic [((($clog2(SLOT_COUNT) + 128 + $clog2(SLOT_COUNT + 1)) + 7) / 8) * 8 - 1:0]
                                                       rsp_tdata,
   // Fields from bit 0 up: status (3).
   output logic [dsa_pkg::STATUS_W-1:0]                rsp_tuser,

   input  logic                                        csr_psel,
   input  logic                                        csr_penable,
   input  logic                                        csr_pwrite,
   input  logic [4:0]                                  csr_paddr,
   input  logic [63:0]                                 csr_pwdata,
   output logic [63:0]                                 csr_prdata,
   output logic                                        csr_pready
);

   localparam int AW         = dsa_pkg::ADDR_W;
   localparam int SW         = dsa_pkg::SIZE_W;
   localparam int IDX_W      = $clog2(SLOT_COUNT);
   localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
   localparam int FR_W       = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
   localparam int PEND_DEPTH = SLOT_COUNT * FRAME_COUNT;
   localparam int PA_W       = $clog2(PEND_DEPTH);
   localparam int ACC_W      = IDX_W + SW;
   localparam int STEP_W     = (IDX_W > 6) ? IDX_W : 6;
   localparam int RSP_RAW    = IDX_W + 2 * AW + CNT_W;
   localparam int RSP_W      = ((RSP_RAW + 7) / 8) * 8;

   localparam logic [3:0] S_INIT    = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_ALC_RD  = 4'd2;
   localparam logic [3:0] S_ALC_MUL = 4'd3;
   localparam logic [3:0] S_ALC_CPU = 4'd4;
   localparam logic [3:0] S_ALC_GPU = 4'd5;
   localparam logic [3:0] S_ALC_FIN = 4'd6;
   localparam logic [3:0] S_FRE_SUB = 4'd7;
   localparam logic [3:0] S_FRE_DIV = 4'd8;
   localparam logic [3:0] S_FRE_CHK = 4'd9;
   localparam logic [3:0] S_RCL_RD  = 4'd10;
   localparam logic [3:0] S_RCL_WR  = 4'd11;
   localparam logic [3:0] S_DONE    = 4'd12;

   // Configuration registers.
   logic [SW-1:0] slot_size_ff;
   logic [AW-1:0] cpu_base_ff;
   logic [AW-1:0] gpu_base_ff;
   logic          shader_ff;
   logic          csr_write;

   // Sequencer and allocator state.
   logic [3:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [CNT_W-1:0]  used_ff, used_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [CNT_W-1:0]  pcount_ff [FRAME_COUNT];
   logic [CNT_W-1:0]  pcount_in [FRAME_COUNT];

   // Latched request.
   logic [dsa_pkg::FRAME_W-1:0]   frame_ff, frame_in;

   // Result being built and the output register.
   logic [dsa_pkg::STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [IDX_W-1:0]              res_slot_ff, res_slot_in;
   logic [AW-1:0]                 res_cpu_ff, res_cpu_in;
   logic [AW-1:0]                 res_gpu_ff, res_gpu_in;
   logic [CNT_W-1:0]              res_recl_ff, res_recl_in;

   logic                          rsp_tvalid_ff, rsp_tvalid_in;
   logic [dsa_pkg::STATUS_W-1:0]  out_status_ff, out_status_in;
   logic [IDX_W-1:0]              out_slot_ff, out_slot_in;
   logic [AW-1:0]                 out_cpu_ff, out_cpu_in;
   logic [AW-1:0]                 out_gpu_ff, out_gpu_in;
   logic [CNT_W-1:0]              out_recl_ff, out_recl_in;

   // Request fields.
   logic [AW-1:0]                 req_addr;
   logic [dsa_pkg::FRAME_W-1:0]   req_frame;
   logic                          req_frame_ok;
   logic [FR_W-1:0]               req_fsel;
   logic [FR_W-1:0]               fsel;
   logic [PA_W-1:0]               pend_base;
   logic [CNT_W-1:0]              rcl_next;

   // Memories and shared unit.
   logic                  fs_we;
   logic [IDX_W-1:0]      fs_waddr, fs_wdata, fs_raddr, fs_rdata;
   logic                  pd_we;
   logic [PA_W-1:0]       pd_waddr, pd_raddr;
   logic [IDX_W-1:0]      pd_wdata, pd_rdata;
   dsa_pkg::arith_cmd_type cmd;
   logic [AW-1:0]         work;
   logic                  borrow;

   dsa_ram #(.WIDTH(IDX_W), .DEPTH(SLOT_COUNT)) u_free_stack (
      .clock   (clock),
      .wr_en   (fs_we),
      .wr_addr (fs_waddr),
      .wr_data (fs_wdata),
      .rd_addr (fs_raddr),
      .rd_data (fs_rdata)
   );

   dsa_ram #(.WIDTH(IDX_W), .DEPTH(PEND_DEPTH)) u_pending (
      .clock   (clock),
      .wr_en   (pd_we),
      .wr_addr (pd_waddr),
      .wr_data (pd_wdata),
      .rd_addr (pd_raddr),
      .rd_data (pd_rdata)
   );

   dsa_arith #(.ACC_W(ACC_W)) u_arith (
      .clock     (clock),
      .cmd       (cmd),
      .slot_size (slot_size_ff),
      .work      (work),
      .borrow    (borrow)
   );

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_size_ff <= SW'(32);
         cpu_base_ff  <= '0;
         gpu_base_ff  <= '0;
         shader_ff    <= 1'b0;
      end else if (csr_write) begin
         case (csr_paddr[4:3])
            dsa_pkg::REG_SLOT_SIZE:      slot_size_ff <= csr_pwdata[SW-1:0];
            dsa_pkg::REG_CPU_BASE:       cpu_base_ff  <= csr_pwdata;
            dsa_pkg::REG_GPU_BASE:       gpu_base_ff  <= csr_pwdata;
            dsa_pkg::REG_SHADER_VISIBLE: shader_ff    <= csr_pwdata[0];
            default:                     shader_ff    <= shader_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:3])
         dsa_pkg::REG_SLOT_SIZE:      csr_prdata = 64'(slot_size_ff);
         dsa_pkg::REG_CPU_BASE:       csr_prdata = cpu_base_ff;
         dsa_pkg::REG_GPU_BASE:       csr_prdata = gpu_base_ff;
         dsa_pkg::REG_SHADER_VISIBLE: csr_prdata = 64'(shader_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   assign req_addr     = req_tdata[63:0];
   assign req_frame    = req_tdata[66:64];
   assign req_frame_ok = ({1'b0, req_frame} < 4'(FRAME_COUNT));
   assign req_fsel     = req_frame[FR_W-1:0];
   assign fsel         = frame_ff[FR_W-1:0];
   assign pend_base    = PA_W'(32'(frame_ff) * SLOT_COUNT);
   assign rcl_next     = CNT_W'(step_ff[IDX_W-1:0]) + CNT_W'(1);

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      used_in       = used_ff;
      total_in      = total_ff;
      pcount_in     = pcount_ff;
      frame_in      = frame_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_cpu_in    = res_cpu_ff;
      res_gpu_in    = res_gpu_ff;
      res_recl_in   = res_recl_ff;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      out_status_in = out_status_ff;
      out_slot_in   = out_slot_ff;
      out_cpu_in    = out_cpu_ff;
      out_gpu_in    = out_gpu_ff;
      out_recl_in   = out_recl_ff;

      cmd.op      = dsa_pkg::OP_HOLD;
      cmd.operand = '0;
      fs_we       = 1'b0;
      fs_waddr    = step_ff[IDX_W-1:0];
      fs_wdata    = step_ff[IDX_W-1:0];
      fs_raddr    = used_ff[IDX_W-1:0];
      pd_we       = 1'b0;
      pd_waddr    = pend_base;
      pd_wdata    = work[IDX_W-1:0];
      pd_raddr    = pend_base + PA_W'(step_ff[IDX_W-1:0]);

      case (state_ff)
         S_INIT: begin
            fs_we   = 1'b1;
            step_in = step_ff + STEP_W'(1);
            if (step_ff[IDX_W-1:0] == IDX_W'(SLOT_COUNT - 1)) begin
               step_in  = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               frame_in      = req_frame;
               res_status_in = dsa_pkg::ST_OK;
               res_slot_in   = '0;
               res_cpu_in    = '0;
               res_gpu_in    = '0;
               res_recl_in   = '0;
               step_in       = '0;
               state_in      = S_DONE;
               case (req_tuser)
                  dsa_pkg::FUNC_ALLOC: begin
                     if (used_ff == CNT_W'(SLOT_COUNT)) begin
                        res_status_in = dsa_pkg::ST_FULL;
                     end else begin
                        state_in = S_ALC_RD;
                     end
                  end
                  dsa_pkg::FUNC_FREE: begin
                     if (req_addr == '0) begin
                        res_status_in = dsa_pkg::ST_NULL;
                     end else if (!req_frame_ok) begin
                        res_status_in = dsa_pkg::ST_FRAME;
                     end else if (slot_size_ff == '0) begin
                        res_status_in = dsa_pkg::ST_BAD;
                     end else begin
                        cmd.op      = dsa_pkg::OP_LOAD;
                        cmd.operand = req_addr;
                        state_in    = S_FRE_SUB;
                     end
                  end
                  dsa_pkg::FUNC_RECLAIM: begin
                     if (!req_frame_ok) begin
                        res_status_in = dsa_pkg::ST_FRAME;
                     end else begin
                        res_recl_in = pcount_ff[req_fsel];
                        if (pcount_ff[req_fsel] != '0) begin
                           state_in = S_RCL_RD;
                        end
                     end
                  end
                  default: begin
                     res_status_in = dsa_pkg::ST_BAD;
                  end
               endcase
            end
         end
         S_ALC_RD: begin
            res_slot_in = fs_rdata;
            cmd.op      = dsa_pkg::OP_LOAD;
            cmd.operand = {fs_rdata, (AW - IDX_W)'(0)};
            used_in     = used_ff + CNT_W'(1);
            step_in     = '0;
            state_in    = S_ALC_MUL;
         end
         S_ALC_MUL: begin
            cmd.op  = dsa_pkg::OP_STEP_MUL;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(IDX_W - 1)) begin
               state_in = S_ALC_CPU;
            end
         end
         S_ALC_CPU: begin
            cmd.op      = dsa_pkg::OP_ADD;
            cmd.operand = cpu_base_ff;
            state_in    = S_ALC_GPU;
         end
         S_ALC_GPU: begin
            res_cpu_in  = work;
            cmd.op      = dsa_pkg::OP_ADD;
            cmd.operand = gpu_base_ff;
            state_in    = S_ALC_FIN;
         end
         S_ALC_FIN: begin
            res_gpu_in = shader_ff ? work : '0;
            state_in   = S_DONE;
         end
         S_FRE_SUB: begin
            cmd.op      = dsa_pkg::OP_SUB;
            cmd.operand = cpu_base_ff;
            step_in     = '0;
            state_in    = S_FRE_DIV;
         end
         S_FRE_DIV: begin
            if (borrow) begin
               res_status_in = dsa_pkg::ST_BAD;
               state_in      = S_DONE;
            end else begin
               cmd.op  = dsa_pkg::OP_STEP_DIV;
               step_in = step_ff + STEP_W'(1);
               if (step_ff == STEP_W'(AW - 1)) begin
                  state_in = S_FRE_CHK;
               end
            end
         end
         S_FRE_CHK: begin
            state_in = S_DONE;
            if (work >= AW'(SLOT_COUNT)) begin
               res_status_in = dsa_pkg::ST_BAD;
            end else if (total_ff >= used_ff) begin
               res_status_in = dsa_pkg::ST_BAD;
            end else begin
               pd_we           = 1'b1;
               pd_waddr        = pend_base + PA_W'(pcount_ff[fsel][IDX_W-1:0]);
               pcount_in[fsel] = pcount_ff[fsel] + CNT_W'(1);
               total_in        = total_ff + CNT_W'(1);
               res_slot_in     = work[IDX_W-1:0];
            end
         end
         S_RCL_RD: begin
            state_in = S_RCL_WR;
         end
         S_RCL_WR: begin
            if (used_ff != '0) begin
               fs_we    = 1'b1;
               fs_waddr = IDX_W'(used_ff - CNT_W'(1));
               fs_wdata = pd_rdata;
               used_in  = used_ff - CNT_W'(1);
            end
            step_in = step_ff + STEP_W'(1);
            if (rcl_next == pcount_ff[fsel]) begin
               pcount_in[fsel] = '0;
               total_in        = total_ff - pcount_ff[fsel];
               state_in        = S_DONE;
            end else begin
               state_in = S_RCL_RD;
            end
         end
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               out_status_in = res_status_ff;
               out_slot_in   = res_slot_ff;
               out_cpu_in    = res_cpu_ff;
               out_gpu_in    = res_gpu_ff;
               out_recl_in   = res_recl_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         step_ff       <= '0;
         used_ff       <= '0;
         total_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
         for (int f = 0; f < FRAME_COUNT; f++) begin
            pcount_ff[f] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         used_ff       <= used_in;
         total_ff      <= total_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         pcount_ff     <= pcount_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff      <= frame_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_cpu_ff    <= res_cpu_in;
      res_gpu_ff    <= res_gpu_in;
      res_recl_ff   <= res_recl_in;
      out_status_ff <= out_status_in;
      out_slot_ff   <= out_slot_in;
      out_cpu_ff    <= out_cpu_in;
      out_gpu_ff    <= out_gpu_in;
      out_recl_ff   <= out_recl_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = RSP_W'({out_recl_ff, out_gpu_ff, out_cpu_ff, out_slot_ff});

endmodule

>>> tb/tb_descriptor_slot_allocator.sv
`timescale 1ns / 100ps

module tb_descriptor_slot_allocator;

   localparam int SLOTS = 256;
   localparam int FRAMES = 3;
   localparam int RSP_W = ((($clog2(SLOTS) + 128 + $clog2(SLOTS + 1)) + 7) / 8) * 8;
   localparam logic [dsa_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int QUIET_LIMIT = 4000;
   localparam int HOLDOFF_CYCLES = 300;

   typedef struct packed {
      logic [dsa_pkg::STATUS_W-1:0] status;
      logic [7:0]                   slot;
      logic [63:0]                  cpu;
      logic [63:0]                  gpu;
      logic [8:0]                   reclaimed;
   } outcome_type;

   // Tracks the heap as the block should see it and queues the outcome of each transaction.
   class allocator_ledger_type;
      logic [12:0] slot_size;
      logic [63:0] cpu_base;
      logic [63:0] gpu_base;
      logic        shader_visible;
      logic [7:0]  free_stack [SLOTS];
      int          used_count;
      logic [7:0]  parked [FRAMES][SLOTS];
      int          parked_count [FRAMES];
      outcome_type expected_outcomes [$];
      int          mismatch_count;

      function new();
         slot_size = 13'd32;
         cpu_base = '0;
         gpu_base = '0;
         shader_visible = 1'b0;
         foreach (free_stack[i]) free_stack[i] = 8'(i);
         used_count = 0;
         foreach (parked_count[f]) parked_count[f] = 0;
         mismatch_count = 0;
      endfunction

      function void set_register(logic [1:0] which, logic [63:0] value);
         case (which)
            dsa_pkg::REG_SLOT_SIZE: slot_size = value[12:0];
            dsa_pkg::REG_CPU_BASE: cpu_base = value;
            dsa_pkg::REG_GPU_BASE: gpu_base = value;
            dsa_pkg::REG_SHADER_VISIBLE: shader_visible = value[0];
            default: ;
         endcase
      endfunction

      function void note_request(logic [dsa_pkg::FUNC_W-1:0] func, logic [63:0] addr,
                                 logic [2:0] frame);
         outcome_type o;
         logic [63:0] offset;
         logic [63:0] quotient;
         int          parked_total;
         int          n;
         o = '0;
         case (func)
            dsa_pkg::FUNC_ALLOC: begin
               if (used_count >= SLOTS) begin
                  o.status = dsa_pkg::ST_FULL;
               end else begin
                  o.slot = free_stack[used_count];
                  offset = 64'(o.slot) * 64'(slot_size);
                  used_count++;
                  o.cpu = cpu_base + offset;
                  o.gpu = shader_visible ? gpu_base + offset : '0;
               end
            end
            dsa_pkg::FUNC_FREE: begin
               parked_total = 0;
               foreach (parked_count[f]) parked_total += parked_count[f];
               quotient = (slot_size == 0) ? '1 : (addr - cpu_base) / 64'(slot_size);
               if (addr == 0) begin
                  o.status = dsa_pkg::ST_NULL;
               end else if (frame >= FRAMES) begin
                  o.status = dsa_pkg::ST_FRAME;
               end else if (slot_size == 0 || addr < cpu_base || quotient >= SLOTS) begin
                  o.status = dsa_pkg::ST_BAD;
               end else if (parked_total >= used_count) begin
                  o.status = dsa_pkg::ST_BAD;
               end else begin
                  o.slot = quotient[7:0];
                  parked[frame][parked_count[frame]] = quotient[7:0];
                  parked_count[frame]++;
               end
            end
            dsa_pkg::FUNC_RECLAIM: begin
               if (frame >= FRAMES) begin
                  o.status = dsa_pkg::ST_FRAME;
               end else begin
                  n = parked_count[frame];
                  for (int k = 0; k < n && used_count > 0; k++) begin
                     used_count--;
                     free_stack[used_count] = parked[frame][k];
                  end
                  parked_count[frame] = 0;
                  o.reclaimed = 9'(n);
               end
            end
            default: o.status = dsa_pkg::ST_BAD;
         endcase
         expected_outcomes.insert(expected_outcomes.size(), o);
      endfunction

      function void check_response(outcome_type got);
         outcome_type want;
         if (expected_outcomes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: result with nothing expected: status %0d slot %0d cpu %h",
                        $realtime, got.status, got.slot, got.cpu,
                        " gpu %h recl %0d", got.gpu, got.reclaimed);
            return;
         end
         want = expected_outcomes.pop_front();
         if (got.status !== want.status || got.slot !== want.slot || got.cpu !== want.cpu ||
             got.gpu !== want.gpu || got.reclaimed !== want.reclaimed) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("%0t: mismatch, expected status %0d slot %0d cpu %h gpu %h recl %0d",
                        $realtime, want.status, want.slot, want.cpu, want.gpu, want.reclaimed);
               $display("%0t:           actual status %0d slot %0d cpu %h gpu %h recl %0d",
                        $realtime, got.status, got.slot, got.cpu, got.gpu, got.reclaimed);
            end
         end
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_tvalid = 1'b0;
   wire                          req_tready;
   logic [71:0]                  req_tdata = '0;
   logic [dsa_pkg::FUNC_W-1:0]   req_tuser = '0;
   wire                          rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   wire [RSP_W-1:0]              rsp_tdata;
   wire [dsa_pkg::STATUS_W-1:0]  rsp_tuser;
   logic                         csr_psel = 1'b0;
   logic                         csr_penable = 1'b0;
   logic                         csr_pwrite = 1'b0;
   logic [4:0]                   csr_paddr = '0;
   logic [63:0]                  csr_pwdata = '0;
   wire [63:0]                   csr_prdata;
   wire                          csr_pready;

   allocator_ledger_type ledger = new();
   bit tx_gaps = 1'b1;
   bit rx_gaps = 1'b1;
   int holdoff_asked = 0;
   int holdoff_seen = 0;
   int holdoff_left = 0;
   int quiet_cycles = 0;

   descriptor_slot_allocator #(
      .SLOT_COUNT (SLOTS),
      .FRAME_COUNT(FRAMES)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            ledger.check_response('{rsp_tuser, rsp_tdata[7:0], rsp_tdata[71:8],
                                    rsp_tdata[135:72], rsp_tdata[144:136]});
         if (holdoff_seen != holdoff_asked) begin
            holdoff_seen = holdoff_asked;
            holdoff_left = HOLDOFF_CYCLES;
         end
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !rx_gaps || $urandom_range(0, 99) >= 37;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_request(input logic [dsa_pkg::FUNC_W-1:0] func,
                               input logic [63:0] addr, input logic [2:0] frame);
      while (tx_gaps && $urandom_range(0, 99) < 37) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'b0, frame, addr};
      req_tuser <= func;
      do @(posedge clock); while (!req_tready);
      ledger.note_request(func, addr, frame);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      while (ledger.expected_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] which, input logic [63:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {which, 3'b000};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      ledger.set_register(which, value);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [12:0] size, input logic [63:0] cpu,
                                 input logic [63:0] gpu, input logic visible);
      write_register(dsa_pkg::REG_SLOT_SIZE, 64'(size));
      write_register(dsa_pkg::REG_CPU_BASE, cpu);
      write_register(dsa_pkg::REG_GPU_BASE, gpu);
      write_register(dsa_pkg::REG_SHADER_VISIBLE, 64'(visible));
   endtask

   function automatic logic [63:0] random_word();
      return {$urandom, $urandom};
   endfunction

   task automatic run_mix(input int count, input int alloc_pct, input int free_pct,
                          input int reclaim_pct);
      int          pick;
      logic [7:0]  idx;
      logic [63:0] addr;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < alloc_pct) begin
            send_request(dsa_pkg::FUNC_ALLOC, random_word(), 3'($urandom_range(0, 7)));
         end else if (pick < alloc_pct + free_pct) begin
            if (ledger.used_count > 0) begin
               idx = ledger.free_stack[$urandom_range(0, ledger.used_count - 1)];
               addr = ledger.cpu_base + 64'(idx) * 64'(ledger.slot_size);
               if (ledger.slot_size > 1 && $urandom_range(0, 3) == 0)
                  addr += 64'($urandom_range(0, ledger.slot_size - 1));
            end else begin
               addr = '0;
            end
            send_request(dsa_pkg::FUNC_FREE, addr, ($urandom_range(0, 15) == 0) ?
                         3'($urandom_range(0, 7)) : 3'($urandom_range(0, FRAMES - 1)));
         end else if (pick < alloc_pct + free_pct + reclaim_pct) begin
            send_request(dsa_pkg::FUNC_RECLAIM, random_word(), ($urandom_range(0, 9) == 0) ?
                         3'($urandom_range(0, 7)) : 3'($urandom_range(0, FRAMES - 1)));
         end else begin
            case ($urandom_range(0, 3))
               0: addr = ledger.cpu_base + 64'(SLOTS) * 64'(ledger.slot_size);
               1: addr = ledger.cpu_base - 64'd1;
               default: addr = random_word();
            endcase
            send_request(2'($urandom_range(0, 3)), addr, 3'($urandom_range(0, 7)));
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_request(dsa_pkg::FUNC_FREE, 64'd0, 3'd0);
      send_request(dsa_pkg::FUNC_FREE, 64'd32, 3'd0);
      send_request(dsa_pkg::FUNC_RECLAIM, 64'd0, 3'd0);
      send_request(dsa_pkg::FUNC_RECLAIM, '1, 3'd7);
      send_request(dsa_pkg::FUNC_RECLAIM, 64'd0, 3'(FRAMES));
      send_request(FUNC_UNUSED, '1, 3'd7);
      send_request(dsa_pkg::FUNC_ALLOC, 64'd0, 3'd0);
      send_request(dsa_pkg::FUNC_ALLOC, '1, 3'd7);
      send_request(dsa_pkg::FUNC_ALLOC, 64'd0, 3'd0);
      send_request(dsa_pkg::FUNC_FREE, 64'd63, 3'd2);
      send_request(dsa_pkg::FUNC_FREE, 64'd64, 3'(FRAMES));
      send_request(dsa_pkg::FUNC_FREE, 64'd32 * SLOTS, 3'd0);
      send_request(dsa_pkg::FUNC_FREE, 64'd32 * (SLOTS - 1) + 64'd31, 3'd1);
      send_request(dsa_pkg::FUNC_FREE, 64'd32, 3'd2);
      send_request(dsa_pkg::FUNC_FREE, 64'd32, 3'd0);
      send_request(dsa_pkg::FUNC_RECLAIM, 64'd0, 3'd2);
      send_request(dsa_pkg::FUNC_ALLOC, 64'd0, 3'd0);
      send_request(dsa_pkg::FUNC_RECLAIM, 64'd0, 3'd1);
      send_request(dsa_pkg::FUNC_FREE, '1, 3'd0);
      settle();

      apply_settings(13'd0, 64'hFFFF_FFFF_FFFF_FFF0, '1, 1'b1);
      send_request(dsa_pkg::FUNC_ALLOC, 64'd0, 3'd0);
      send_request(dsa_pkg::FUNC_FREE, 64'hFFFF_FFFF_FFFF_FFF0, 3'd0);
      send_request(dsa_pkg::FUNC_FREE, 64'd1, 3'd0);
      send_request(dsa_pkg::FUNC_ALLOC, 64'd0, 3'd0);
      settle();

      // No idling on either side here; the receiver first holds off so the block backs up.
      apply_settings(13'd1, random_word(), random_word(), 1'b1);
      tx_gaps = 1'b0;
      rx_gaps = 1'b0;
      holdoff_asked++;
      run_mix(150, 85, 8, 4);
      settle();
      tx_gaps = 1'b1;
      rx_gaps = 1'b1;

      apply_settings(13'd4096, 64'd0 - 64'd4096 * 64'd100, '1, 1'b1);
      run_mix(200, 90, 5, 2);
      settle();

      apply_settings(13'h1FFF, random_word(), random_word(), 1'b0);
      run_mix(150, 35, 35, 20);
      settle();

      apply_settings(13'($urandom_range(1, 4096)), random_word(), random_word(),
                     1'($urandom_range(0, 1)));
      run_mix(50, 35, 35, 20);
      settle();
      run_mix(50, 35, 35, 20);
      settle();

      repeat (600) @(posedge clock);
      if (ledger.mismatch_count == 0 && ledger.expected_outcomes.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

>>> filelist.f
src/dsa_pkg.sv
src/dsa_ram.sv
src/dsa_arith.sv
src/descriptor_slot_allocator.sv
tb/tb_descriptor_slot_allocator.sv
